// ===== design/bbpa_pkg.sv =====
package bbpa_pkg;

	// Pool geometry. Both counts are powers of two, so a bank and a slot form
	// a store address by concatenation.
	localparam int NUM_BANKS = 16;
	localparam int PER_BANK  = 16;

	localparam int ID_W   = 8;
	localparam int BANK_W = $clog2(NUM_BANKS);
	localparam int SLOT_W = $clog2(PER_BANK);
	localparam int CNT_W  = SLOT_W + 1;
	localparam int ADDR_W = BANK_W + SLOT_W;
	localparam int DEPTH  = NUM_BANKS * PER_BANK;

	// Request modes.
	localparam logic MODE_TAKE = 1'b0;
	localparam logic MODE_GIVE = 1'b1;

	typedef struct packed {
		logic            mode;
		logic [ID_W-1:0] buffer_id;
	} in_item_t;

	typedef struct packed {
		logic            granted;
		logic [ID_W-1:0] granted_id;
		logic            error;
	} out_item_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic look;
		logic deliver;
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic out_free;
	} dp_status_t;

endpackage

// ===== design/bbpa_ctrl.sv =====
module bbpa_ctrl import bbpa_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  dp_status_t status,
	output ctrl_cmd_t  cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_LOOK = 2'd1;
	localparam logic [1:0] ST_FIN  = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	// Next state and commands.
	always_comb begin
		state_d     = state_q;
		cmd.capture = 1'b0;
		cmd.look    = 1'b0;
		cmd.deliver = 1'b0;
		in_stall    = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_LOOK;
				end
			end
			ST_LOOK: begin
				cmd.look = 1'b1;
				state_d  = ST_FIN;
			end
			ST_FIN: begin
				if (status.out_free) begin
					cmd.deliver = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== design/bbpa_datapath.sv =====
module bbpa_datapath import bbpa_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  ctrl_cmd_t  cmd,
	output dp_status_t status,
	input  in_item_t   in_data,
	output logic       out_valid,
	input  logic       out_stall,
	output out_item_t  out_data
);

	// Captured request.
	logic            mode_q;
	logic [ID_W-1:0] id_q;

	// Bank bookkeeping.
	logic [BANK_W-1:0] tp_q;
	logic [SLOT_W-1:0] head_q  [NUM_BANKS];
	logic [CNT_W-1:0]  count_q [NUM_BANKS];

	// Buffer store, its written marks and the registered read.
	logic [ID_W-1:0]   store_q [DEPTH];
	logic [DEPTH-1:0]  vld_q;
	logic [ID_W-1:0]   rd_data_q;
	logic              rd_vld_q;
	logic [ADDR_W-1:0] rd_addr_q;

	// Result held between lookup and delivery, and the output register.
	logic      granted_q;
	logic      error_q;
	logic      out_valid_q;
	out_item_t out_q;

	logic [ID_W-1:0]   home;
	logic              home_ok;
	logic [BANK_W-1:0] sel_bank;
	logic [SLOT_W-1:0] hd;
	logic [CNT_W-1:0]  cnt;
	logic [SLOT_W-1:0] wr_slot;
	logic [ADDR_W-1:0] mem_addr;
	logic              take_hit;
	logic              give_ok;
	logic              mem_we;
	logic [ID_W-1:0]   grant_value;

	// Bank selection and the decision for the captured request.
	always_comb begin
		home     = id_q >> SLOT_W;
		home_ok  = home < ID_W'(NUM_BANKS);
		sel_bank = (mode_q == MODE_GIVE) ? home[BANK_W-1:0] : tp_q;
		hd       = head_q[sel_bank];
		cnt      = count_q[sel_bank];
		wr_slot  = hd + cnt[SLOT_W-1:0];
		take_hit = (mode_q == MODE_TAKE) && (cnt != '0);
		give_ok  = (mode_q == MODE_GIVE) && home_ok && (cnt < CNT_W'(PER_BANK));
		mem_addr = (mode_q == MODE_GIVE) ? {sel_bank, wr_slot} : {sel_bank, hd};
		mem_we   = cmd.look && give_ok;
	end

	// Request capture on an input transfer.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_q <= in_data.mode;
			id_q   <= in_data.buffer_id;
		end
	end

	// Round-robin pointer and per-bank head and count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tp_q <= '0;
			for (int k = 0; k < NUM_BANKS; k++) begin
				head_q[k]  <= '0;
				count_q[k] <= CNT_W'(PER_BANK);
			end
		end else if (cmd.look) begin
			if (mode_q == MODE_TAKE) begin
				tp_q <= (tp_q == BANK_W'(NUM_BANKS - 1)) ? '0 : tp_q + 1'b1;
			end
			if (take_hit) begin
				head_q[sel_bank]  <= hd + 1'b1;
				count_q[sel_bank] <= cnt - 1'b1;
			end else if (give_ok) begin
				count_q[sel_bank] <= cnt + 1'b1;
			end
		end
	end

	// Store array with a registered read port.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			store_q[mem_addr] <= id_q;
		end
		if (cmd.look) begin
			rd_data_q <= store_q[mem_addr];
			rd_addr_q <= mem_addr;
		end
	end

	// Written marks: an entry never written reads back as its own address.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else if (cmd.look) begin
			if (mem_we) begin
				vld_q[mem_addr] <= 1'b1;
			end
			rd_vld_q <= vld_q[mem_addr];
		end
	end

	// Outcome flags of the lookup.
	always_ff @(posedge clk) begin
		if (cmd.look) begin
			granted_q <= take_hit;
			error_q   <= (mode_q == MODE_GIVE) && !give_ok;
		end
	end

	assign grant_value = rd_vld_q ? rd_data_q : ID_W'(rd_addr_q);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.deliver) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.deliver) begin
			out_q.granted    <= granted_q;
			out_q.granted_id <= granted_q ? grant_value : '0;
			out_q.error      <= error_q;
		end
	end

	assign status.out_free = !out_valid_q || !out_stall;
	assign out_valid       = out_valid_q;
	assign out_data        = out_q;

endmodule

// ===== design/banked_buffer_pool_allocator.sv =====
// Channel | Handshake            | Payload
// --------+----------------------+-------------------------------------
// in      | in_valid / in_stall   | in_data  : mode, buffer_id
// out     | out_valid / out_stall | out_data : granted, granted_id, error
//
// Each request passes through the transfer, a bank lookup that issues the store
// access, and a final step in which the registered store read is loaded into
// the output register. A new request is taken while the last result waits.
// Reset is immediate: every bank is full and the store needs no clearing pass,
// as an entry never written reads back its own address.
// A stalled output holds the finished request in its final step until it drains.
module banked_buffer_pool_allocator import bbpa_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_data
);

	ctrl_cmd_t  cmd;
	dp_status_t status;

	bbpa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	bbpa_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	// One request at a time: after an input transfer the input is stalled.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input taken while a request is in progress");

	// A result never both grants and flags an error.
	a_grant_xor_error: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_data.granted && out_data.error))
		else $error("result both granted and in error");

	// A result without a grant carries a zero id.
	a_zero_id: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_data.granted) |-> (out_data.granted_id == '0))
		else $error("non-zero id without a grant");

	// A result does not follow an input transfer at once: the lookup comes between.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && (!out_valid || !out_stall)) |=> !out_valid)
		else $error("result appeared too early");

endmodule
